### rtl/mpsm_pkg.sv
// Shared types and constants for the multi-pattern stream matcher.
package mpsm_pkg;

  // Geometry of the pattern store
  localparam int PATTERNS = 4;
  localparam int MAX_LEN  = 32;
  localparam int LEN_W    = $clog2(MAX_LEN + 1);
  localparam int IDX_W    = $clog2(MAX_LEN);

  // Request opcodes
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2,
    OP_LOAD  = 2'd3
  } op_t;

  // Result kinds
  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_TIMEOUT = 1'b1;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data_byte;
    logic [23:0] timeout_ticks;
    logic [1:0]  pattern_sel;
    logic [4:0]  position;
    logic        is_last;
  } req_t;

  typedef struct packed {
    logic       result_kind;
    logic [1:0] pattern_index;
  } rsp_t;

  // Per-pattern control from the top level
  typedef struct packed {
    logic       clear;     // start: drop match position
    logic       step;      // received byte, not blocked by a lower pattern
    logic       load;      // pattern byte write for this pattern
    logic       last;      // load also sets the length
    logic [7:0] data;
    logic [4:0] position;
  } lane_ctl_t;

endpackage

### rtl/mpsm_lane.sv
// One pattern: byte store, length, match position and compare logic.
module mpsm_lane (
  input  logic               clk,
  input  logic               rst,
  input  mpsm_pkg::lane_ctl_t ctl,
  output logic               complete
);

  logic [7:0]                 mem [mpsm_pkg::MAX_LEN];
  logic [7:0]                 rd_data;     // pattern byte at the effective position
  logic [7:0]                 first_byte;
  logic [mpsm_pkg::LEN_W-1:0] len, len_next;
  logic [mpsm_pkg::LEN_W-1:0] cur, cur_next;
  logic [mpsm_pkg::LEN_W-1:0] eff, eff_next, hit_pos, pos_ext;
  logic [mpsm_pkg::IDX_W-1:0] waddr, raddr;
  logic                       active, hit;

  assign pos_ext = mpsm_pkg::LEN_W'(ctl.position);
  assign waddr   = pos_ext[mpsm_pkg::IDX_W-1:0];

  // Compare against the prefetched byte
  assign active   = len != '0;
  assign eff      = (cur >= len) ? '0 : cur;
  assign hit      = ctl.data == rd_data;
  assign hit_pos  = eff + mpsm_pkg::LEN_W'(1);
  assign complete = active && hit && (hit_pos == len);

  // Next length and position
  always_comb begin
    len_next = len;
    cur_next = cur;
    if (ctl.load && ctl.last) begin
      len_next = pos_ext + mpsm_pkg::LEN_W'(1);
    end
    if (ctl.clear || ctl.load) begin
      cur_next = '0;
    end else if (ctl.step && active) begin
      if (hit) begin
        cur_next = hit_pos;
      end else begin
        cur_next = (ctl.data == first_byte) ? mpsm_pkg::LEN_W'(1) : '0;
      end
    end
  end

  // Fetch the byte the next request will compare against
  assign eff_next = (cur_next >= len_next) ? '0 : cur_next;
  assign raddr    = eff_next[mpsm_pkg::IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      cur <= '0;
    end else begin
      len <= len_next;
      cur <= cur_next;
    end
  end

  // Pattern memory, read data forwarded on a same-address write
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mem[waddr] <= ctl.data;
    end
    if (ctl.load && waddr == raddr) begin
      rd_data <= ctl.data;
    end else begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && ctl.position == '0) begin
      first_byte <= ctl.data;
    end
  end

endmodule

### rtl/multi_pattern_stream_matcher.sv
// Top level: request register, pattern lanes, arm/timeout control, result register.
//
// Takes one request per clock unless stalled; its result, if any, is registered
// after the request register; a full result register that is stalled holds the
// request register, so at most two requests are in flight. Start clears all
// match positions and arms with a tick limit (a zero limit times out at once);
// received bytes are compared against every pattern in the same cycle, and the
// lowest-numbered pattern that completes is reported and disarms the matcher;
// ticks count toward the limit and reaching it reports a timeout. Each pattern
// keeps its bytes in its own small memory with a registered read that fetches
// the byte for the next compare ahead of time. Pattern bytes may be loaded at
// any time; loading a pattern resets its match position.
module multi_pattern_stream_matcher (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  mpsm_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output mpsm_pkg::rsp_t rsp
);

  mpsm_pkg::req_t            req_q;
  logic                      req_q_valid;
  logic                      go, proc;
  logic                      is_start, is_tick, byte_go, load_ok;
  logic                      armed, armed_next;
  logic [23:0]               elapsed, elapsed_next, elapsed_inc;
  logic [23:0]               limit, limit_next;
  mpsm_pkg::lane_ctl_t       lane_ctl [mpsm_pkg::PATTERNS];
  logic [mpsm_pkg::PATTERNS-1:0] complete, step_en, match_vec;
  logic                      found;
  logic [1:0]                found_idx;
  logic                      res_load;
  mpsm_pkg::rsp_t            res_data;

  // Request register
  assign go        = !(rsp_valid && rsp_stall);
  assign req_stall = req_q_valid && !go;
  assign proc      = req_q_valid && go;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else if (!req_stall) begin
      req_q_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_q <= req;
    end
  end

  // Decode
  assign is_start = proc && req_q.op == mpsm_pkg::OP_START;
  assign is_tick  = proc && req_q.op == mpsm_pkg::OP_TICK && armed;
  assign byte_go  = proc && req_q.op == mpsm_pkg::OP_BYTE && armed;
  assign load_ok  = proc && req_q.op == mpsm_pkg::OP_LOAD
                    && (32'(req_q.position) < mpsm_pkg::MAX_LEN);

  // Lowest completing pattern blocks all higher ones
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    step_en   = '0;
    for (int i = 0; i < mpsm_pkg::PATTERNS; i++) begin
      step_en[i] = byte_go && !found;
      if (byte_go && !found && complete[i]) begin
        found     = 1'b1;
        found_idx = 2'(i);
      end
    end
  end

  assign match_vec = complete & step_en;

  // Pattern lanes
  for (genvar g = 0; g < mpsm_pkg::PATTERNS; g++) begin : g_lane
    always_comb begin
      lane_ctl[g].clear    = is_start;
      lane_ctl[g].step     = step_en[g];
      lane_ctl[g].load     = load_ok && (32'(req_q.pattern_sel) == g);
      lane_ctl[g].last     = req_q.is_last;
      lane_ctl[g].data     = req_q.data_byte;
      lane_ctl[g].position = req_q.position;
    end

    mpsm_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctl      (lane_ctl[g]),
      .complete (complete[g])
    );
  end

  // Arm, tick count and result selection
  assign elapsed_inc = elapsed + 24'd1;

  always_comb begin
    armed_next   = armed;
    elapsed_next = elapsed;
    limit_next   = limit;
    res_load     = 1'b0;
    res_data     = '{result_kind: mpsm_pkg::KIND_TIMEOUT, pattern_index: 2'd0};
    if (is_start) begin
      elapsed_next = '0;
      limit_next   = req_q.timeout_ticks;
      if (req_q.timeout_ticks == '0) begin
        armed_next = 1'b0;
        res_load   = 1'b1;
      end else begin
        armed_next = 1'b1;
      end
    end else if (byte_go && found) begin
      armed_next = 1'b0;
      res_load   = 1'b1;
      res_data   = '{result_kind: mpsm_pkg::KIND_MATCH, pattern_index: found_idx};
    end else if (is_tick) begin
      elapsed_next = elapsed_inc;
      if (elapsed_inc >= limit) begin
        armed_next = 1'b0;
        res_load   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed   <= 1'b0;
      elapsed <= '0;
      limit   <= '0;
    end else begin
      armed   <= armed_next;
      elapsed <= elapsed_next;
      limit   <= limit_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (go) begin
      rsp_valid <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res_load) begin
      rsp <= res_data;
    end
  end

  // Checks
  a_one_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match_vec))
    else $error("more than one pattern reported on one byte");

  a_zero_limit: assert property (@(posedge clk) disable iff (rst)
    is_start && req_q.timeout_ticks == '0 |=>
      rsp_valid && rsp.result_kind == mpsm_pkg::KIND_TIMEOUT && !armed)
    else $error("zero tick limit did not time out at once");

  a_disarm_reports: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(armed) |-> $past(res_load) || $past(is_start))
    else $error("matcher disarmed without a result");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> req_q_valid && rsp_valid)
    else $error("request stalled with room to proceed");

endmodule
